// ----- sv/scs_pkg.sv -----
// scs_pkg: shared types, constants and the control store of the sensor channel smoother.
// No dependencies; used by sensor_channel_smoother.
package scs_pkg;

    // Field widths fixed by the item format
    localparam int unsigned SAMPLE_BITS = 10;
    localparam int unsigned CH_BITS     = 2;
    localparam int unsigned KIND_BITS   = 2;
    localparam int unsigned MV_BITS     = 16;
    localparam int unsigned TEMP_BITS   = 11;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned NUM_CH_DEF  = 4;

    // Datapath widths
    localparam int unsigned MUL_A_W = 11;                 // level or clamped die difference
    localparam int unsigned MUL_B_W = 16;                 // weight, scale or gain
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
    localparam int unsigned ACC_W   = SAMPLE_BITS + 5;    // sum of two weighted terms, /32
    localparam int unsigned W_BITS  = 6;

    localparam logic [W_BITS-1:0] W_FULL      = 6'd32;
    localparam logic [ACC_W-1:0]  ROUND_HALF  = 15'd16;
    localparam logic [18:0]       TEMP_ROUND  = 19'h80;
    localparam logic [11:0]       KELVIN_OFS  = 12'd273;
    localparam logic [11:0]       TEMP_MAX    = 12'd1023;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_SCALE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_GAIN     = 3'd4;

    // Channel roles
    localparam logic [CH_BITS-1:0] CH_VOLT = 2'd0;
    localparam logic [CH_BITS-1:0] CH_DIE  = 2'd3;

    // Result kinds
    localparam logic [KIND_BITS-1:0] KIND_LEVEL = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_MV    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_TEMP  = 2'd2;

    // Microprogram
    typedef logic [1:0] step_t;

    localparam step_t STEP_FETCH  = 2'd0;   // take a sample, multiply by weight
    localparam step_t STEP_BLEND  = 2'd1;   // add old level term, store new level
    localparam step_t STEP_CAL    = 2'd2;   // calibration multiply
    localparam step_t STEP_RESULT = 2'd3;   // offset, round, load output register

    typedef enum logic [1:0] {
        MUL_NEW,    // sample * w
        MUL_OLD,    // old level * (32 - w)
        MUL_CAL,    // level * scale or clamped diff * gain
        MUL_NONE
    } mul_sel_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN,    // input transfer on a stored channel
        COND_OUT    // output register free
    } cond_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     acc_load;   // acc <= product
        logic     acc_blend;  // acc + product + 1/2, write level
        logic     prod_load;  // keep full product
        logic     out_load;   // finish result into output register
        logic     in_ready;   // input channel open
        cond_t    cond;       // jump to target when met, else hold
        step_t    target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t uw;
        uw = '0;
        unique case (step)
            STEP_FETCH: begin
                uw.mul_sel  = MUL_NEW;
                uw.acc_load = 1'b1;
                uw.in_ready = 1'b1;
                uw.cond     = COND_IN;
                uw.target   = STEP_BLEND;
            end
            STEP_BLEND: begin
                uw.mul_sel   = MUL_OLD;
                uw.acc_blend = 1'b1;
                uw.cond      = COND_ALWAYS;
                uw.target    = STEP_CAL;
            end
            STEP_CAL: begin
                uw.mul_sel   = MUL_CAL;
                uw.prod_load = 1'b1;
                uw.cond      = COND_ALWAYS;
                uw.target    = STEP_RESULT;
            end
            STEP_RESULT: begin
                uw.mul_sel  = MUL_NONE;
                uw.out_load = 1'b1;
                uw.cond     = COND_OUT;
                uw.target   = STEP_FETCH;
            end
            default: begin
                uw = '0;
            end
        endcase
        return uw;
    endfunction

endpackage

// ----- sv/sensor_channel_smoother.sv -----
// sensor_channel_smoother: per-channel exponential smoothing with voltage and die
// temperature calibration, run by a four-step microprogram. Depends on scs_pkg.
//
// Usage
//   Input channel (s_valid/s_ready, s_channel, s_sample): one converter sample tagged
//   with its channel. Result channel (m_valid/m_ready, m_*): channel, new smoothed
//   level, kind, and millivolts (channel 0) or die temperature in C (channel 3).
//   Unused result fields read zero. A channel with no stored level (>= NUM_CH) is
//   taken and dropped: no state change, no result.
//   Configuration: cfg_wr_en/cfg_index/cfg_wdata, one register per cycle, no wait;
//   writes to unknown indexes are ignored. Write only while the block is idle.
//   Operation: a transfer on the input starts a fixed four-step program on one shared
//   11x16 multiplier (weight multiply, blend, calibration multiply, finish). The
//   result is registered at the end of the fourth step. The input is open only in
//   the first step, so a new sample is taken only once the last one's result is
//   loaded. The multiplier, used by three dependent steps, is why the steps run in series.
//   Stall: the finish step holds until the output register is free (empty or being
//   taken), so a stalled receiver stops the input with one result buffered and one held.
//   Reset (aresetn low, synchronous): levels cleared to zero, registers to their
//   defaults (weight 8, scale 1024, rest zero), output register empty.
module sensor_channel_smoother #(
    parameter int unsigned NUM_CH = scs_pkg::NUM_CH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [scs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [scs_pkg::CH_BITS-1:0]         s_channel,
    input  logic [scs_pkg::SAMPLE_BITS-1:0]     s_sample,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [scs_pkg::CH_BITS-1:0]         m_out_channel,
    output logic [scs_pkg::SAMPLE_BITS-1:0]     m_level,
    output logic [scs_pkg::KIND_BITS-1:0]       m_kind,
    output logic [scs_pkg::MV_BITS-1:0]         m_millivolts,
    output logic signed [scs_pkg::TEMP_BITS-1:0] m_temperature_c
);

    localparam int unsigned CH_IDX_W = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

    // ---------------- configuration registers ----------------
    logic [scs_pkg::W_BITS-1:0]  filter_weight_reg;
    logic [15:0]                 volt_scale_reg;
    logic [15:0]                 volt_offset_reg;
    logic [7:0]                  temp_offset_reg;
    logic [7:0]                  temp_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_weight_reg <= 6'd8;
            volt_scale_reg    <= 16'd1024;
            volt_offset_reg   <= '0;
            temp_offset_reg   <= '0;
            temp_gain_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                scs_pkg::REG_FILTER_WEIGHT: filter_weight_reg <= cfg_wdata[scs_pkg::W_BITS-1:0];
                scs_pkg::REG_VOLT_SCALE:    volt_scale_reg    <= cfg_wdata;
                scs_pkg::REG_VOLT_OFFSET:   volt_offset_reg   <= cfg_wdata;
                scs_pkg::REG_TEMP_OFFSET:   temp_offset_reg   <= cfg_wdata[7:0];
                scs_pkg::REG_TEMP_GAIN:     temp_gain_reg     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // weights above full scale act as full scale
    logic [scs_pkg::W_BITS-1:0] w_sat;
    logic [scs_pkg::W_BITS-1:0] w_old;
    assign w_sat = (filter_weight_reg > scs_pkg::W_FULL) ? scs_pkg::W_FULL : filter_weight_reg;
    assign w_old = scs_pkg::W_FULL - w_sat;

    // ---------------- sequencer ----------------
    scs_pkg::step_t  step_reg, step_next;
    scs_pkg::ucode_t uw;
    logic            cond_ok;
    logic            ch_ok;
    logic            out_free;

    assign uw       = scs_pkg::ucode_rom(step_reg);
    assign s_ready  = uw.in_ready;
    assign ch_ok    = (32'(s_channel) < NUM_CH);
    assign out_free = !m_valid || m_ready;

    always_comb begin
        case (uw.cond)
            scs_pkg::COND_ALWAYS: cond_ok = 1'b1;
            scs_pkg::COND_IN:     cond_ok = s_valid && ch_ok;
            scs_pkg::COND_OUT:    cond_ok = out_free;
            default:              cond_ok = 1'b0;
        endcase
        step_next = cond_ok ? uw.target : step_reg;
    end

    // ---------------- datapath ----------------
    logic [scs_pkg::SAMPLE_BITS-1:0] level_mem [NUM_CH];
    logic [scs_pkg::CH_BITS-1:0]     ch_reg;
    logic [CH_IDX_W-1:0]             ch_idx;
    logic [scs_pkg::ACC_W-1:0]       acc_reg;
    logic [scs_pkg::ACC_W-1:0]       acc_sum;
    logic [scs_pkg::SAMPLE_BITS-1:0] level_reg;
    logic [scs_pkg::PROD_W-1:0]      prod_reg;

    assign ch_idx = CH_IDX_W'(ch_reg);

    // die difference, clamped at zero: level - sext(offset) in 12-bit signed
    logic signed [11:0]              die_diff;
    logic [scs_pkg::MUL_A_W-1:0]     die_clamp;
    assign die_diff  = $signed({2'b00, level_reg}) - 12'(signed'(temp_offset_reg));
    assign die_clamp = die_diff[11] ? '0 : die_diff[10:0];

    // shared multiplier operands
    logic [scs_pkg::MUL_A_W-1:0] mul_a;
    logic [scs_pkg::MUL_B_W-1:0] mul_b;
    logic [scs_pkg::PROD_W-1:0]  prod;

    always_comb begin
        case (uw.mul_sel)
            scs_pkg::MUL_NEW: begin
                mul_a = scs_pkg::MUL_A_W'(s_sample);
                mul_b = scs_pkg::MUL_B_W'(w_sat);
            end
            scs_pkg::MUL_OLD: begin
                mul_a = scs_pkg::MUL_A_W'(level_mem[ch_idx]);
                mul_b = scs_pkg::MUL_B_W'(w_old);
            end
            scs_pkg::MUL_CAL: begin
                if (ch_reg == scs_pkg::CH_DIE) begin
                    mul_a = die_clamp;
                    mul_b = scs_pkg::MUL_B_W'(temp_gain_reg);
                end else begin
                    mul_a = scs_pkg::MUL_A_W'(level_reg);
                    mul_b = volt_scale_reg;
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = scs_pkg::PROD_W'(mul_a) * scs_pkg::PROD_W'(mul_b);
    end

    // the two weights add up to 32, so the sum stays below 32 * 1024 and fits ACC_W
    assign acc_sum = acc_reg + prod[scs_pkg::ACC_W-1:0] + scs_pkg::ROUND_HALF;

    // result formatting
    logic [15:0]                 mv_val;
    logic [18:0]                 t_round;
    logic signed [11:0]          t_c;
    logic [scs_pkg::TEMP_BITS-1:0] t_sat;
    logic [scs_pkg::KIND_BITS-1:0] kind_val;

    always_comb begin
        mv_val  = prod_reg[25:10] + volt_offset_reg;
        t_round = prod_reg[18:0] + scs_pkg::TEMP_ROUND;
        t_c     = $signed({1'b0, t_round[18:8]}) - $signed(scs_pkg::KELVIN_OFS);
        t_sat   = (t_c > $signed(scs_pkg::TEMP_MAX)) ? scs_pkg::TEMP_MAX[10:0] : t_c[10:0];
        case (ch_reg)
            scs_pkg::CH_VOLT: kind_val = scs_pkg::KIND_MV;
            scs_pkg::CH_DIE:  kind_val = scs_pkg::KIND_TEMP;
            default:          kind_val = scs_pkg::KIND_LEVEL;
        endcase
    end

    // control state
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= scs_pkg::STEP_FETCH;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                level_mem[i] <= '0;
            end
        end else begin
            step_reg <= step_next;
            if (uw.out_load && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (uw.acc_blend) begin
                level_mem[ch_idx] <= acc_sum[scs_pkg::ACC_W-1:5];
            end
        end
    end

    // payload registers
    logic [scs_pkg::CH_BITS-1:0]     m_channel_reg;
    logic [scs_pkg::SAMPLE_BITS-1:0] m_level_reg;
    logic [scs_pkg::KIND_BITS-1:0]   m_kind_reg;
    logic [scs_pkg::MV_BITS-1:0]     m_mv_reg;
    logic [scs_pkg::TEMP_BITS-1:0]   m_temp_reg;

    always_ff @(posedge aclk) begin
        if (uw.in_ready && s_valid) begin
            ch_reg <= s_channel;
        end
        if (uw.acc_load) begin
            acc_reg <= prod[scs_pkg::ACC_W-1:0];
        end
        if (uw.acc_blend) begin
            level_reg <= acc_sum[scs_pkg::ACC_W-1:5];
        end
        if (uw.prod_load) begin
            prod_reg <= prod;
        end
        if (uw.out_load && out_free) begin
            m_channel_reg <= ch_reg;
            m_level_reg   <= level_reg;
            m_kind_reg    <= kind_val;
            m_mv_reg      <= (kind_val == scs_pkg::KIND_MV)   ? mv_val : '0;
            m_temp_reg    <= (kind_val == scs_pkg::KIND_TEMP) ? t_sat  : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_channel   = m_channel_reg;
    assign m_level         = m_level_reg;
    assign m_kind          = m_kind_reg;
    assign m_millivolts    = m_mv_reg;
    assign m_temperature_c = $signed(m_temp_reg);

endmodule
